FILE: hdl/prit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prit_pkg
// Shared types, widths and register map for the position/rate/integral
// tracker.
// ----------------------------------------------------------------------------
package prit_pkg;

    localparam int RAW_W      = 8;
    localparam int POS_W      = 8;
    localparam int RATE_W     = 7;
    localparam int INTEG_W    = 12;
    localparam int DB_W       = 3;
    localparam int JL_W       = 6;
    localparam int IL_W       = 10;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [DB_W-1:0] DEAD_BAND_RST      = 3'd1;
    localparam logic [JL_W-1:0] JUMP_LIMIT_RST     = 6'd8;
    localparam logic [IL_W-1:0] INTEGRAL_LIMIT_RST = 10'd100;

    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [RATE_W-1:0]  rate_t;
    typedef logic signed [INTEG_W-1:0] integ_t;

    typedef enum logic [1:0] {
        REG_DEAD_BAND      = 2'd0,
        REG_JUMP_LIMIT     = 2'd1,
        REG_INTEGRAL_LIMIT = 2'd2
    } reg_index_t;

    // Raw byte to signed position: above 127 gives 255 - raw, else -raw.
    function automatic pos_t map_position(input logic [RAW_W-1:0] raw);
        logic [POS_W-1:0] res;
        if (raw[RAW_W-1])
            res = ~raw;
        else
            res = {POS_W{1'b0}} - raw;
        return pos_t'(res);
    endfunction

endpackage

FILE: hdl/position_rate_integral_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_rate_integral_tracker
// Maps raw position bytes to signed position, dead-banded spike-held rate and
// a limited, sign-reset integral of position.
// ----------------------------------------------------------------------------
// A beat is accepted every clock cycle unless the input register is full and
// stalled; each beat yields one result beat via the input register, then the
// result register. The sustained rate is set by the update of the previous
// position, previous rate and integral state as a beat enters that register.
// Registers: 0x0 dead_band, 0x4 jump_limit, 0x8 integral_limit.
module position_rate_integral_tracker
    import prit_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [RAW_W-1:0]    raw_sample,

    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [POS_W-1:0]   position,
    output logic signed [RATE_W-1:0]  rate,
    output logic signed [INTEG_W-1:0] integral
);

    logic [DB_W-1:0]  dead_band_reg;
    logic [JL_W-1:0]  jump_limit_reg;
    logic [IL_W-1:0]  integral_limit_reg;

    logic             s1_valid_reg;
    logic [RAW_W-1:0] s1_raw_reg;

    pos_t             prev_pos_reg,  prev_pos_next;
    rate_t            prev_rate_reg, prev_rate_next;
    integ_t           integ_reg,     integ_next;

    logic             out_valid_reg;
    pos_t             out_pos_reg;
    rate_t            out_rate_reg;
    integ_t           out_integ_reg;

    logic             advance;
    logic             accept;
    logic             cfg_wr;
    reg_index_t       cfg_idx;

    pos_t                   pos;
    logic signed [POS_W:0]  rate_full;
    logic [POS_W:0]         rate_mag;
    logic [POS_W-2:0]       pos_mag;
    logic [INTEG_W-2:0]     integ_mag;
    logic                   rate_dead;
    logic                   rate_hold;
    logic                   flip;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_index_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_band_reg      <= DEAD_BAND_RST;
            jump_limit_reg     <= JUMP_LIMIT_RST;
            integral_limit_reg <= INTEGRAL_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_DEAD_BAND:      dead_band_reg      <= pwdata[DB_W-1:0];
                REG_JUMP_LIMIT:     jump_limit_reg     <= pwdata[JL_W-1:0];
                REG_INTEGRAL_LIMIT: integral_limit_reg <= pwdata[IL_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_DEAD_BAND:      prdata = {{(DATA_W-DB_W){1'b0}}, dead_band_reg};
            REG_JUMP_LIMIT:     prdata = {{(DATA_W-JL_W){1'b0}}, jump_limit_reg};
            REG_INTEGRAL_LIMIT: prdata = {{(DATA_W-IL_W){1'b0}}, integral_limit_reg};
            default:            prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_raw_reg <= raw_sample;
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        pos       = map_position(s1_raw_reg);
        pos_mag   = pos[POS_W-1] ? (POS_W-1)'(-pos) : pos[POS_W-2:0];
        rate_full = {prev_pos_reg[POS_W-1], prev_pos_reg} - {pos[POS_W-1], pos};
        rate_mag  = rate_full[POS_W] ? (POS_W+1)'(-rate_full) : rate_full;
        integ_mag = integ_reg[INTEG_W-1] ? (INTEG_W-1)'(-integ_reg)
                                         : integ_reg[INTEG_W-2:0];

        rate_dead = rate_mag <= {{(POS_W+1-DB_W){1'b0}}, dead_band_reg};
        rate_hold = !rate_dead
                    && (rate_mag > {{(POS_W+1-JL_W){1'b0}}, jump_limit_reg});

        if (rate_dead)
            prev_rate_next = '0;
        else if (rate_hold)
            prev_rate_next = prev_rate_reg;
        else
            prev_rate_next = rate_full[RATE_W-1:0];

        flip = (!pos[POS_W-1] && (pos != '0) && prev_pos_reg[POS_W-1])
            || (pos[POS_W-1] && !prev_pos_reg[POS_W-1] && (prev_pos_reg != '0));

        if (pos_mag <= {{(POS_W-1-DB_W){1'b0}}, dead_band_reg} || flip)
            integ_next = '0;
        else if (integ_mag < {{(INTEG_W-1-IL_W){1'b0}}, integral_limit_reg})
            integ_next = integ_reg + {{(INTEG_W-POS_W){pos[POS_W-1]}}, pos};
        else
            integ_next = integ_reg;

        prev_pos_next = pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg  <= '0;
            prev_rate_reg <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                prev_pos_reg  <= prev_pos_next;
                prev_rate_reg <= prev_rate_next;
                integ_reg     <= integ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_pos_reg   <= prev_pos_next;
            out_rate_reg  <= prev_rate_next;
            out_integ_reg <= integ_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = out_pos_reg;
    assign rate      = out_rate_reg;
    assign integral  = out_integ_reg;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_beat_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> out_valid_reg)
        else $error("beat lost between input and result register");

    a_rate_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_rate_reg != {1'b1, {(RATE_W-1){1'b0}}}))
        else $error("rate outside jump-limited range");

    a_dead_band_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance
            && (pos_mag <= {{(POS_W-1-DB_W){1'b0}}, dead_band_reg}))
        |=> (out_integ_reg == '0))
        else $error("integral not cleared inside dead band");
`endif

endmodule

FILE: sim/position_rate_integral_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_rate_integral_checker
// Watches the register bus and both beat channels of the tracker. Keeps its
// own copy of the settings and of the tracker state, predicts position, rate
// and integral for every accepted sample and compares each result beat with
// the oldest prediction.
// ----------------------------------------------------------------------------
module position_rate_integral_checker
    import prit_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,

    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [RAW_W-1:0]    raw_sample,

    input  logic                out_valid,
    input  logic                out_stall,
    input  pos_t                position,
    input  rate_t               rate,
    input  integ_t              integral,

    output int                  mismatches,
    output int                  pending
);

    typedef struct {
        pos_t   position;
        rate_t  rate;
        integ_t integral;
    } tracker_beat_t;

    logic [DB_W-1:0] dead_band;
    logic [JL_W-1:0] jump_limit;
    logic [IL_W-1:0] integral_limit;

    pos_t   last_position;
    rate_t  last_rate;
    integ_t running_sum;

    tracker_beat_t expected_beats[$];

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Advances the tracker state by one raw sample and returns the result.
    function automatic tracker_beat_t track_sample(input logic [RAW_W-1:0] raw);
        tracker_beat_t res;
        int p;
        int prev;
        int r;
        int acc;
        p    = (raw > 127) ? 255 - int'(raw) : -int'(raw);
        prev = int'(last_position);
        acc  = int'(running_sum);
        r    = prev - p;
        if (mag(r) <= int'(dead_band))
            r = 0;
        if (mag(p) > int'(dead_band))
        begin
            if ((p > 0 && prev < 0) || (p < 0 && prev > 0))
                acc = 0;
            else if (mag(acc) < int'(integral_limit))
                acc = acc + p;
        end
        else
            acc = 0;
        // spike hold comes after the dead band test
        if (mag(r) > int'(jump_limit))
            r = int'(last_rate);
        last_position = pos_t'(p);
        last_rate     = rate_t'(r);
        running_sum   = integ_t'(acc);
        res.position  = pos_t'(p);
        res.rate      = rate_t'(r);
        res.integral  = integ_t'(acc);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tracker_beat_t want;
        if (!rst_n)
        begin
            dead_band      = DEAD_BAND_RST;
            jump_limit     = JUMP_LIMIT_RST;
            integral_limit = INTEGRAL_LIMIT_RST;
            last_position  = '0;
            last_rate      = '0;
            running_sum    = '0;
            expected_beats.delete();
            mismatches     = 0;
            pending       <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                unique case (paddr[ADDR_W-1:2])
                    REG_DEAD_BAND:      dead_band      = pwdata[DB_W-1:0];
                    REG_JUMP_LIMIT:     jump_limit     = pwdata[JL_W-1:0];
                    REG_INTEGRAL_LIMIT: integral_limit = pwdata[IL_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected result beat: position %0d rate %0d integral %0d",
                             $time, position, rate, integral);
                    mismatches++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (position !== want.position)
                    begin
                        $display("%0t: position mismatch: expected %0d, actual %0d",
                                 $time, want.position, position);
                        mismatches++;
                    end
                    if (rate !== want.rate)
                    begin
                        $display("%0t: rate mismatch: expected %0d, actual %0d",
                                 $time, want.rate, rate);
                        mismatches++;
                    end
                    if (integral !== want.integral)
                    begin
                        $display("%0t: integral mismatch: expected %0d, actual %0d",
                                 $time, want.integral, integral);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_beats.push_back(track_sample(raw_sample));
            pending <= expected_beats.size();
        end
    end

endmodule

FILE: sim/tb_position_rate_integral_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_position_rate_integral_tracker
// Drives raw position bytes into the tracker under random source gaps and
// sink stalls, across several register settings including the extremes.
// Starts with hand-picked samples, then smooth position walks mixed with
// random bytes. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_position_rate_integral_tracker;
    import prit_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_stall;
    logic [RAW_W-1:0]    raw_sample;
    logic                out_valid;
    logic                out_stall;
    pos_t                position;
    rate_t               rate;
    integ_t              integral;

    int mismatches;
    int pending;
    int cycle_count;
    int walk_pos;
    logic quiet;

    position_rate_integral_tracker dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_sample (raw_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position   (position),
        .rate       (rate),
        .integral   (integral)
    );

    position_rate_integral_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_sample (raw_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position   (position),
        .rate       (rate),
        .integral   (integral),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 28);

    task automatic send_beat(input logic [RAW_W-1:0] b);
        if (!quiet)
            while ($urandom_range(99) < 28)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid   <= 1'b1;
        raw_sample <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every result beat is back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly smooth walks with steps around the jump limit, some big jumps,
    // and some fully random bytes. Junk above each register width is masked.
    task automatic run_phase(input int db, input int jl, input int il, input int n,
                             input logic q);
        int step;
        logic [RAW_W-1:0] b;
        settle();
        apb_write(REG_DEAD_BAND,      ($urandom << DB_W) | db);
        apb_write(REG_JUMP_LIMIT,     ($urandom << JL_W) | jl);
        apb_write(REG_INTEGRAL_LIMIT, ($urandom << IL_W) | il);
        quiet <= q;
        repeat (n)
        begin
            if ($urandom_range(99) < 20)
                b = RAW_W'($urandom_range(255));
            else
            begin
                step = $urandom_range(jl + 6);
                if ($urandom_range(99) < 8)
                    step = $urandom_range(127);
                if ($urandom_range(1))
                    step = -step;
                walk_pos = walk_pos + step;
                if (walk_pos > 127)
                    walk_pos = 127;
                if (walk_pos < -127)
                    walk_pos = -127;
                if (walk_pos > 0)
                    b = RAW_W'(255 - walk_pos);
                else if (walk_pos == 0 && $urandom_range(1))
                    b = 8'd255;
                else
                    b = RAW_W'(-walk_pos);
            end
            walk_pos = (b > 127) ? 255 - int'(b) : -int'(b);
            send_beat(b);
        end
    endtask

    initial
    begin
        logic [RAW_W-1:0] directed[] = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd1, 8'd254,
                                         8'd130, 8'd125, 8'd120, 8'd128, 8'd128, 8'd128,
                                         8'd128, 8'd0, 8'd131, 8'd133, 8'd135, 8'd140,
                                         8'd10, 8'd8, 8'd6, 8'd255, 8'd0, 8'd3};
        clk         = 1'b0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        raw_sample  = '0;
        out_stall   = 1'b0;
        quiet       = 1'b0;
        cycle_count = 0;
        walk_pos    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero crossings, extremes, big jumps, integral limit
        foreach (directed[i])
            send_beat(directed[i]);
        settle();
        apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);

        run_phase(7, 63, 1023, 200, 1'b0);
        run_phase(0, 0, 0, 200, 1'b0);
        run_phase(7, 0, 0, 150, 1'b0);
        run_phase(0, 63, 1023, 200, 1'b1);
        run_phase(1, 8, 100, 150, 1'b0);
        repeat (4)
            run_phase($urandom_range(7), $urandom_range(63),
                      ($urandom_range(1) ? $urandom_range(200) : $urandom_range(1023)),
                      200, 1'b0);

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
